[src/hbc_pkg.sv]
// hbc_pkg: shared types and constants for the histogram bin counter.
// No dependencies; used by hbc_ram, histogram_bin_counter and the testbench.
package hbc_pkg;

  localparam int NUM_BINS_DEF   = 1024;
  localparam int COUNT_BITS_DEF = 32;

  localparam int SAMPLE_W    = 32;
  localparam int INV_W       = 32;
  localparam int PROD_W      = SAMPLE_W + INV_W;
  localparam int IDX_W       = 32;
  localparam int OUT_BIN_W   = 10;
  localparam int OUT_COUNT_W = 32;
  localparam int TOTAL_W     = 32;
  localparam int STATUS_W    = 2;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [INV_W-1:0] INV_BIN_WIDTH_RST = INV_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_BIN_WIDTH = 1'b0
  } reg_idx_t;

  typedef enum logic {
    REQ_PUSH  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK           = 2'd0,
    STAT_NOT_FINITE   = 2'd1,
    STAT_OUT_OF_RANGE = 2'd2
  } status_t;

endpackage

[src/histogram_bin_counter.sv]
// histogram_bin_counter: fixed-width histogram, bin counts held in hbc_ram.
// Depends on hbc_pkg and hbc_ram.
//
//   channel | ports                               | word
//   in      | in_valid/in_ready                   | req_type, sample, not_finite
//   out     | out_valid/out_ready                 | status, bin, counts, range, empty
//   cfg     | cfg_psel/penable/pwrite/paddr/...   | inv_bin_width at byte 0
//
// Four stages: input register, 32x32 multiply, round/range check with the RAM
// read, then read-modify-write into the output register. One word per cycle
// while out_ready is high. After reset a clearing pass writes NUM_BINS zero
// words, one per cycle, and in_ready stays low until it ends. Stages hold
// while the output is stalled.
module histogram_bin_counter #(
  parameter int NUM_BINS   = hbc_pkg::NUM_BINS_DEF,
  parameter int COUNT_BITS = hbc_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_req_type,
  input  logic signed [hbc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                               in_not_finite,

  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hbc_pkg::STATUS_W-1:0]       out_status,
  output logic signed [hbc_pkg::OUT_BIN_W-1:0] out_bin_index,
  output logic [hbc_pkg::OUT_COUNT_W-1:0]    out_bin_count,
  output logic [hbc_pkg::TOTAL_W-1:0]        out_sample_total,
  output logic signed [hbc_pkg::OUT_BIN_W-1:0] out_lowest_bin,
  output logic signed [hbc_pkg::OUT_BIN_W-1:0] out_highest_bin,
  output logic                               out_is_empty,

  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [hbc_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [hbc_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [hbc_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  localparam int SLOT_W = $clog2(NUM_BINS);
  localparam int HALF   = NUM_BINS / 2;
  localparam logic [SLOT_W-1:0] HALF_S    = SLOT_W'(HALF);
  localparam logic [SLOT_W-1:0] TOP_SLOT  = SLOT_W'(2 * HALF - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BINS - 1);
  localparam logic [hbc_pkg::IDX_W-1:0] IDX_HALF    = hbc_pkg::IDX_W'(HALF);
  localparam logic [hbc_pkg::IDX_W-1:0] IDX_HALF_M1 = hbc_pkg::IDX_W'(HALF - 1);
  localparam logic [hbc_pkg::PROD_W-1:0] ROUND_HALF = hbc_pkg::PROD_W'(64'h8000_0000);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [hbc_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;

  // configuration
  logic [hbc_pkg::INV_W-1:0] inv_bin_width_r;
  logic                      cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit = cfg_paddr[hbc_pkg::CFG_ADDR_W-1:2] == hbc_pkg::REG_INV_BIN_WIDTH;
  assign cfg_prdata = cfg_hit ? hbc_pkg::CFG_DATA_W'(inv_bin_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_bin_width_r <= hbc_pkg::INV_BIN_WIDTH_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      inv_bin_width_r <= hbc_pkg::INV_W'(cfg_pwdata);
    end
  end

  // clearing pass
  logic              clr_busy_r;
  logic [SLOT_W-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_SLOT) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // pipeline control
  logic va_r, vb_r, vc_r, out_valid_r;
  logic go_b, go_c, go_out;

  assign go_out   = vc_r && (!out_valid_r || out_ready);
  assign go_c     = vb_r && (!vc_r || go_out);
  assign go_b     = va_r && (!vb_r || go_c);
  assign in_ready = !clr_busy_r && (!va_r || go_b);

  // stage A: input register with magnitude
  logic                         a_req_r, a_nf_r, a_neg_r;
  logic [hbc_pkg::SAMPLE_W-1:0] a_mag_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_req_r <= in_req_type;
      a_nf_r  <= in_not_finite;
      a_neg_r <= in_sample[hbc_pkg::SAMPLE_W-1];
      a_mag_r <= in_sample[hbc_pkg::SAMPLE_W-1] ? 0 - unsigned'(in_sample)
                                                 : unsigned'(in_sample);
    end
  end

  // stage B: product
  logic                       b_req_r, b_nf_r, b_neg_r;
  logic [hbc_pkg::PROD_W-1:0] b_prod_r;

  always_ff @(posedge clk) begin
    if (go_b) begin
      b_req_r  <= a_req_r;
      b_nf_r   <= a_nf_r;
      b_neg_r  <= a_neg_r;
      b_prod_r <= hbc_pkg::PROD_W'(a_mag_r) * hbc_pkg::PROD_W'(inv_bin_width_r);
    end
  end

  // stage B -> C: rounding, range check, slot and RAM read
  logic [hbc_pkg::PROD_W-1:0] b_rnd;
  logic [hbc_pkg::IDX_W-1:0]  b_idx;
  logic                       b_oor;
  logic [SLOT_W-1:0]          b_slot;

  always_comb begin
    b_rnd = b_prod_r + ROUND_HALF;
    b_idx = b_rnd[hbc_pkg::PROD_W-1:hbc_pkg::PROD_W-hbc_pkg::IDX_W];
    b_oor = b_neg_r ? (b_idx > IDX_HALF) : (b_idx > IDX_HALF_M1);
    if (b_oor) begin
      b_slot = b_neg_r ? '0 : TOP_SLOT;
    end else if (b_neg_r) begin
      b_slot = HALF_S - b_idx[SLOT_W-1:0];
    end else begin
      b_slot = HALF_S + b_idx[SLOT_W-1:0];
    end
  end

  logic              c_req_r, c_nf_r, c_oor_r;
  logic [SLOT_W-1:0] c_slot_r;

  always_ff @(posedge clk) begin
    if (go_c) begin
      c_req_r  <= b_req_r;
      c_nf_r   <= b_nf_r;
      c_oor_r  <= b_oor;
      c_slot_r <= b_slot;
    end
  end

  // count RAM
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;

  hbc_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (go_c),
    .raddr (b_slot),
    .rdata (ram_rdata)
  );

  // stage C: modify and write back, forwarding the last write
  logic                  wr_vld_r;
  logic [SLOT_W-1:0]     wr_addr_r;
  logic [COUNT_BITS-1:0] wr_data_r;

  logic [hbc_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic signed [SLOT_W-1:0]    min_r, min_nxt, max_r, max_nxt;
  logic                        empty_r, empty_nxt;

  logic                  c_push;
  logic [COUNT_BITS-1:0] c_old, c_new;
  logic signed [SLOT_W-1:0] c_bin;
  hbc_pkg::status_t      c_status;

  always_comb begin
    c_old  = (wr_vld_r && wr_addr_r == c_slot_r) ? wr_data_r : ram_rdata;
    c_new  = (c_old != COUNT_MAX) ? c_old + 1'b1 : c_old;
    c_push = !c_nf_r && !c_oor_r && (c_req_r == hbc_pkg::REQ_PUSH);
    c_bin  = signed'(c_slot_r - HALF_S);
    if (c_nf_r) begin
      c_status = hbc_pkg::STAT_NOT_FINITE;
    end else if (c_oor_r) begin
      c_status = hbc_pkg::STAT_OUT_OF_RANGE;
    end else begin
      c_status = hbc_pkg::STAT_OK;
    end

    total_nxt = total_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    empty_nxt = empty_r;
    if (c_push) begin
      if (total_r != TOTAL_MAX) begin
        total_nxt = total_r + 1'b1;
      end
      if (empty_r) begin
        min_nxt   = c_bin;
        max_nxt   = c_bin;
        empty_nxt = 1'b0;
      end else begin
        if (c_bin < min_r) begin
          min_nxt = c_bin;
        end
        if (c_bin > max_r) begin
          max_nxt = c_bin;
        end
      end
    end

    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = go_out && c_push;
      ram_waddr = c_slot_r;
      ram_wdata = c_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_vld_r <= 1'b0;
      total_r  <= '0;
      min_r    <= '0;
      max_r    <= '0;
      empty_r  <= 1'b1;
    end else if (go_out) begin
      total_r <= total_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
      empty_r <= empty_nxt;
      if (c_push) begin
        wr_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_out && c_push) begin
      wr_addr_r <= c_slot_r;
      wr_data_r <= c_new;
    end
  end

  // output register
  logic [hbc_pkg::STATUS_W-1:0]          status_r;
  logic signed [hbc_pkg::OUT_BIN_W-1:0]  bin_r, low_r, high_r;
  logic [hbc_pkg::OUT_COUNT_W-1:0]       count_r;
  logic [hbc_pkg::TOTAL_W-1:0]           total_out_r;
  logic                                  empty_out_r;

  always_ff @(posedge clk) begin
    if (go_out) begin
      status_r    <= c_status;
      bin_r       <= c_nf_r ? '0 : hbc_pkg::OUT_BIN_W'(c_bin);
      if (c_nf_r || c_oor_r) begin
        count_r <= '0;
      end else if (c_push) begin
        count_r <= hbc_pkg::OUT_COUNT_W'(c_new);
      end else begin
        count_r <= hbc_pkg::OUT_COUNT_W'(c_old);
      end
      total_out_r <= total_nxt;
      low_r       <= hbc_pkg::OUT_BIN_W'(min_nxt);
      high_r      <= hbc_pkg::OUT_BIN_W'(max_nxt);
      empty_out_r <= empty_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        va_r <= 1'b1;
      end else if (go_b) begin
        va_r <= 1'b0;
      end
      if (go_b) begin
        vb_r <= 1'b1;
      end else if (go_c) begin
        vb_r <= 1'b0;
      end
      if (go_c) begin
        vc_r <= 1'b1;
      end else if (go_out) begin
        vc_r <= 1'b0;
      end
      if (go_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_bin_index    = bin_r;
  assign out_bin_count    = count_r;
  assign out_sample_total = total_out_r;
  assign out_lowest_bin   = low_r;
  assign out_highest_bin  = high_r;
  assign out_is_empty     = empty_out_r;

endmodule

[src/hbc_ram.sv]
// hbc_ram: generic single-write, single-read RAM with registered read data.
// Depends on hbc_pkg for default sizes.
module hbc_ram #(
  parameter int WIDTH = hbc_pkg::COUNT_BITS_DEF,
  parameter int DEPTH = hbc_pkg::NUM_BINS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/hbc_checker.sv]
// hbc_checker: watches the histogram counter's input, result and register ports,
// predicts every result word from its own copy of the bins and compares them.
// Depends on hbc_pkg; instantiated next to the block by tb_histogram_bin_counter.
module hbc_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic                                in_req_type,
  input  logic signed [hbc_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_not_finite,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [hbc_pkg::STATUS_W-1:0]        out_status,
  input  logic [hbc_pkg::OUT_BIN_W-1:0]       out_bin_index,
  input  logic [hbc_pkg::OUT_COUNT_W-1:0]     out_bin_count,
  input  logic [hbc_pkg::TOTAL_W-1:0]         out_sample_total,
  input  logic [hbc_pkg::OUT_BIN_W-1:0]       out_lowest_bin,
  input  logic [hbc_pkg::OUT_BIN_W-1:0]       out_highest_bin,
  input  logic                                out_is_empty,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [hbc_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [hbc_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  input  logic [hbc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  input  logic                                cfg_pready,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  words_checked,
  output int                                  clamped_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HALF = hbc_pkg::NUM_BINS_DEF / 2;

  typedef struct {
    hbc_pkg::status_t                status;
    logic [hbc_pkg::OUT_BIN_W-1:0]   bin;
    logic [hbc_pkg::OUT_COUNT_W-1:0] count;
    logic [hbc_pkg::TOTAL_W-1:0]     total;
    logic [hbc_pkg::OUT_BIN_W-1:0]   lowest;
    logic [hbc_pkg::OUT_BIN_W-1:0]   highest;
    logic                            empty;
  } hist_word_t;

  logic [hbc_pkg::COUNT_BITS_DEF-1:0] tally [hbc_pkg::NUM_BINS_DEF];
  logic [hbc_pkg::TOTAL_W-1:0]        total;
  longint                             lo_bin;
  longint                             hi_bin;
  logic                               hist_empty;
  logic [hbc_pkg::INV_W-1:0]          recip;
  hist_word_t                         predicted_words [$];
  int                                 errs;
  int                                 seen;
  int                                 clamped;

  assign fail_count    = errs;
  assign words_checked = seen;
  assign clamped_words = clamped;

  initial begin
    errs    = 0;
    seen    = 0;
    clamped = 0;
  end

  // sample * recip, rounded half away from zero
  function automatic longint round_to_bin(logic signed [hbc_pkg::SAMPLE_W-1:0] smp,
                                          logic [hbc_pkg::INV_W-1:0] r);
    longint     sv;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] idx;
    sv   = smp;
    mag  = (sv < 0) ? -sv : sv;
    prod = mag * {32'b0, r};
    idx  = (prod + 64'h8000_0000) >> 32;
    return (sv < 0) ? -longint'(idx) : longint'(idx);
  endfunction

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errs++;
    end
  endtask

  task automatic predict_word(hbc_pkg::req_t req, logic signed [hbc_pkg::SAMPLE_W-1:0] smp,
                              logic nf);
    hist_word_t w;
    longint     b;
    int         slot;
    w.status = hbc_pkg::STAT_OK;
    w.count  = '0;
    b        = 0;
    if (nf) begin
      w.status = hbc_pkg::STAT_NOT_FINITE;
    end else begin
      b = round_to_bin(smp, recip);
      if (b < -HALF || b > HALF - 1) begin
        w.status = hbc_pkg::STAT_OUT_OF_RANGE;
        b = (b < -HALF) ? -HALF : HALF - 1;
        clamped++;
      end else begin
        slot = int'(b + HALF);
        if (req == hbc_pkg::REQ_PUSH) begin
          if (tally[slot] != '1) tally[slot] = tally[slot] + 1'b1;
          if (total != '1) total = total + 1'b1;
          if (hist_empty) begin
            lo_bin     = b;
            hi_bin     = b;
            hist_empty = 1'b0;
          end else begin
            if (b < lo_bin) lo_bin = b;
            if (b > hi_bin) hi_bin = b;
          end
        end
        w.count = tally[slot][hbc_pkg::OUT_COUNT_W-1:0];
      end
    end
    w.bin     = b[hbc_pkg::OUT_BIN_W-1:0];
    w.total   = total;
    w.lowest  = lo_bin[hbc_pkg::OUT_BIN_W-1:0];
    w.highest = hi_bin[hbc_pkg::OUT_BIN_W-1:0];
    w.empty   = hist_empty;
    predicted_words = {predicted_words, w};
  endtask

  always @(posedge clk) begin
    hist_word_t w;
    if (!rst_n) begin
      foreach (tally[i]) tally[i] = '0;
      total      = '0;
      lo_bin     = 0;
      hi_bin     = 0;
      hist_empty = 1'b1;
      recip      = hbc_pkg::INV_BIN_WIDTH_RST;
      predicted_words.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (hbc_pkg::reg_idx_t'(cfg_paddr[hbc_pkg::CFG_ADDR_W-1:2]) ==
              hbc_pkg::REG_INV_BIN_WIDTH)
            recip = cfg_pwdata;
        end else begin
          compare_field("prdata", recip, cfg_prdata);
        end
      end
      if (out_valid && out_ready) begin
        if (predicted_words.size() == 0) begin
          $display("%0t: result word with nothing predicted, status %0d bin %h",
                   $time, out_status, out_bin_index);
          errs++;
        end else begin
          w = predicted_words.pop_front();
          seen++;
          compare_field("status", w.status, out_status);
          compare_field("bin_index", w.bin, out_bin_index);
          compare_field("bin_count", w.count, out_bin_count);
          compare_field("sample_total", w.total, out_sample_total);
          compare_field("lowest_bin", w.lowest, out_lowest_bin);
          compare_field("highest_bin", w.highest, out_highest_bin);
          compare_field("is_empty", w.empty, out_is_empty);
        end
      end
      if (in_valid && in_ready)
        predict_word(hbc_pkg::req_t'(in_req_type), in_sample, in_not_finite);
    end
    pending <= predicted_words.size();
  end

endmodule

[tb/tb_histogram_bin_counter.sv]
// tb_histogram_bin_counter: drives directed and random push/query words and
// reciprocal settings into histogram_bin_counter; hbc_checker scores results.
// Depends on hbc_pkg, histogram_bin_counter and hbc_checker.
module tb_histogram_bin_counter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                             LIMIT      = 400000;
  localparam int                             RAND_WORDS = 112;
  localparam logic [hbc_pkg::CFG_ADDR_W-1:0] INV_ADDR   =
    {hbc_pkg::REG_INV_BIN_WIDTH, 2'b00};
  localparam logic [hbc_pkg::CFG_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
  localparam logic [31:0]                    ONE        = 32'h0001_0000;

  localparam hbc_pkg::req_t PUSH  = hbc_pkg::REQ_PUSH;
  localparam hbc_pkg::req_t QUERY = hbc_pkg::REQ_QUERY;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic                                in_req_type;
  logic signed [hbc_pkg::SAMPLE_W-1:0] in_sample;
  logic                                in_not_finite;
  logic                                out_valid;
  logic                                out_ready;
  logic [hbc_pkg::STATUS_W-1:0]        out_status;
  logic signed [hbc_pkg::OUT_BIN_W-1:0] out_bin_index;
  logic [hbc_pkg::OUT_COUNT_W-1:0]     out_bin_count;
  logic [hbc_pkg::TOTAL_W-1:0]         out_sample_total;
  logic signed [hbc_pkg::OUT_BIN_W-1:0] out_lowest_bin;
  logic signed [hbc_pkg::OUT_BIN_W-1:0] out_highest_bin;
  logic                                out_is_empty;
  logic                                cfg_psel;
  logic                                cfg_penable;
  logic                                cfg_pwrite;
  logic [hbc_pkg::CFG_ADDR_W-1:0]      cfg_paddr;
  logic [hbc_pkg::CFG_DATA_W-1:0]      cfg_pwdata;
  logic [hbc_pkg::CFG_DATA_W-1:0]      cfg_prdata;
  logic                                cfg_pready;

  int          fail_count;
  int          pending;
  int          words_checked;
  int          clamped_words;
  int          cycle_cnt = 0;
  int          settings_run = 1;
  int          ready_hold = 0;
  logic        no_gaps = 1'b0;
  logic [31:0] recip_now = ONE;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  histogram_bin_counter dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_sample, .in_not_finite,
    .out_valid, .out_ready, .out_status, .out_bin_index, .out_bin_count,
    .out_sample_total, .out_lowest_bin, .out_highest_bin, .out_is_empty,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  hbc_checker u_check (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_sample, .in_not_finite,
    .out_valid, .out_ready, .out_status,
    .out_bin_index(out_bin_index[hbc_pkg::OUT_BIN_W-1:0]),
    .out_bin_count, .out_sample_total,
    .out_lowest_bin(out_lowest_bin[hbc_pkg::OUT_BIN_W-1:0]),
    .out_highest_bin(out_highest_bin[hbc_pkg::OUT_BIN_W-1:0]),
    .out_is_empty,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready,
    .fail_count, .pending, .words_checked, .clamped_words
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // result-side backpressure: runs of ready, short stalls, occasional long ones
  always @(posedge clk) begin
    int r;
    if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      r = $urandom_range(99);
      if (r < 10) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(200, 30);
      end else if (r < 60) begin
        out_ready <= 1'b1;
        ready_hold = $urandom_range(12);
      end else if (r < 94) begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(2);
      end else begin
        out_ready <= 1'b0;
        ready_hold = $urandom_range(40, 10);
      end
    end
  end

  task automatic send_word(hbc_pkg::req_t req, logic [31:0] smp, logic nf);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_sample     <= smp;
    in_not_finite <= nf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic source_gap();
    int r;
    int gap;
    r   = $urandom_range(99);
    gap = 0;
    if (!no_gaps) begin
      if (r >= 95) gap = $urandom_range(30, 8);
      else if (r >= 70) gap = $urandom_range(3, 1);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put(hbc_pkg::req_t req, logic [31:0] smp, logic nf = 1'b0);
    send_word(req, smp, nf);
    source_gap();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_access(logic wr, logic [hbc_pkg::CFG_ADDR_W-1:0] addr,
                            logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_recip(logic [31:0] v);
    drain();
    cfg_access(1'b1, INV_ADDR, v);
    cfg_access(1'b0, INV_ADDR, '0);
    recip_now = v;
    settings_run++;
  endtask

  // aims mostly at bins in and just past the stored range for the current width
  function automatic logic [31:0] pick_sample(logic [31:0] r_inv);
    longint tgt;
    longint num;
    int     r;
    r = $urandom_range(99);
    if (r < 15 || r_inv == 0) return $urandom;
    if (r < 35) tgt = longint'($urandom_range(6)) - 3;
    else tgt = longint'($urandom_range(1040)) - 520;
    num = (tgt <<< 32) + (longint'($urandom) - 64'sh8000_0000);
    num = num / longint'(r_inv);
    if (num > 64'sh7FFF_FFFF) num = 64'sh7FFF_FFFF;
    if (num < -64'sh8000_0000) num = -64'sh8000_0000;
    return num[31:0];
  endfunction

  task automatic random_words(int n);
    hbc_pkg::req_t req;
    logic          nf;
    for (int k = 0; k < n; k++) begin
      no_gaps = (k % 50) < 15;
      req     = ($urandom_range(99) < 65) ? PUSH : QUERY;
      nf      = $urandom_range(99) < 5;
      put(req, pick_sample(recip_now), nf);
    end
    no_gaps = 1'b0;
  endtask

  task automatic extreme_words();
    put(PUSH, 32'h7FFF_FFFF);
    put(PUSH, 32'h8000_0000);
    put(QUERY, 32'h7FFF_FFFF);
    put(PUSH, 32'h0000_0000);
  endtask

  initial begin
    in_valid      = 1'b0;
    in_req_type   = 1'b0;
    in_sample     = '0;
    in_not_finite = 1'b0;
    out_ready     = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    rst_n         = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_access(1'b0, INV_ADDR, '0);

    // empty histogram, rounding, range edges, rejects, back-to-back same bin
    put(QUERY, 32'h0000_0000);
    put(PUSH, 32'h7FFF_FFFF, 1'b1);
    put(QUERY, 32'h0000_0000, 1'b1);
    put(PUSH, 32'h0000_0000);
    put(PUSH, 32'h0000_8000);
    put(PUSH, 32'hFFFF_8000);
    put(PUSH, 32'h0000_7FFF);
    put(PUSH, 32'(511 * 65536));
    put(PUSH, 32'(511 * 65536 + 32767));
    put(PUSH, 32'(-512 * 65536));
    put(PUSH, 32'(511 * 65536 + 32768));
    put(PUSH, 32'(-512 * 65536 - 32768));
    put(PUSH, 32'h7FFF_FFFF);
    put(PUSH, 32'h8000_0000);
    put(QUERY, 32'(511 * 65536));
    put(QUERY, 32'h8000_0000);
    put(QUERY, 32'(100 * 65536));
    no_gaps = 1'b1;
    put(PUSH, 32'(5 * 65536));
    put(PUSH, 32'(5 * 65536));
    put(PUSH, 32'(5 * 65536));
    put(QUERY, 32'(5 * 65536));
    no_gaps = 1'b0;
    random_words(RAND_WORDS);

    set_recip(32'h0004_0000);
    extreme_words();
    random_words(RAND_WORDS);

    set_recip(32'hFFFF_FFFF);
    extreme_words();
    random_words(RAND_WORDS);

    set_recip(32'h0000_0001);
    extreme_words();
    random_words(RAND_WORDS);

    set_recip(32'h0000_0000);
    extreme_words();
    random_words(RAND_WORDS);

    set_recip($urandom_range(32'h0010_0000, 32'h0000_1000));
    extreme_words();
    random_words(RAND_WORDS);

    // write to an unmapped slot must leave the reciprocal alone
    drain();
    cfg_access(1'b1, UNMAPPED_ADDR, $urandom);
    cfg_access(1'b0, INV_ADDR, '0);
    random_words(RAND_WORDS / 2);
    set_recip(ONE);
    extreme_words();
    random_words(RAND_WORDS / 2);

    drain();
    $display("Checked %0d result words (%0d clamped outside the stored range)",
             words_checked, clamped_words);
    $display("across %0d reciprocal settings including zero, one and all-ones.",
             settings_run);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
